@@ hw/rtl/blake2b_384_hash_macros.svh @@
// ----------------------------------------------------------------------------
// BLAKE2b-384 assertion macros
// Shorthand for the concurrent checks used in the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef BLAKE2B_384_HASH_MACROS_SVH
`define BLAKE2B_384_HASH_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define B2B_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define B2B_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/b2b_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLAKE2b-384 package
// Constants, tables and the control/status structs shared by the hash blocks.
// ----------------------------------------------------------------------------
package b2b_pkg;

   localparam int DIGEST_WORDS_DEF = 6;
   localparam int ROUNDS           = 12;
   localparam int BLOCK_WORDS      = 16;

   // Parameter block word 0: fanout 1, depth 1, no key (digest length added later)
   localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0000;

   localparam logic [63:0] IV [8] = '{
      64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
      64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
      64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
      64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
   };

   // Message schedule, one row per round
   localparam logic [3:0] PERM [ROUNDS][BLOCK_WORDS] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
   };

   // Front end -> compression core
   typedef struct packed {
      logic        start;      // begin a compression
      logic        final_blk;  // last block of the message
      logic [4:0]  nv;         // buffer words that hold data, rest read as zero
      logic [63:0] cnt_lo;
      logic [63:0] cnt_hi;
      logic        wr_en;      // block buffer write
      logic [3:0]  wr_addr;
      logic [63:0] wr_data;
      logic        shift;      // step chain value toward word 0
      logic        reinit;     // chain value back to IV xor parameter block
   } core_ctrl_type;

   // Compression core -> front end
   typedef struct packed {
      logic        done;
      logic [63:0] h0;
   } core_stat_type;

endpackage

@@ hw/rtl/b2b_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLAKE2b compression core
// Block buffer, chain value and one shared quarter-G adder stepped by a
// round/G/quarter sequencer. Rows of the work vector rotate in place.
// ----------------------------------------------------------------------------
module b2b_core #(
   parameter int DIGEST_WORDS = b2b_pkg::DIGEST_WORDS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  b2b_pkg::core_ctrl_type ctrl,
   output b2b_pkg::core_stat_type stat
);
   import b2b_pkg::*;

   localparam logic [3:0]  LastRound = 4'(ROUNDS - 1);
   localparam logic [63:0] H0Init    = IV[0] ^ PARAM_WORD ^ 64'(8 * DIGEST_WORDS);
   localparam logic [63:0] HInit [8] = '{
      H0Init, IV[1], IV[2], IV[3], IV[4], IV[5], IV[6], IV[7]
   };

   typedef enum logic [1:0] {C_IDLE, C_LOAD, C_RUN, C_FOLD} cst_type;

   cst_type     state_ff, state_in;
   logic [3:0]  r_ff, r_in;
   logic [2:0]  g_ff, g_in;
   logic [1:0]  q_ff, q_in;
   logic        final_ff, final_in;
   logic [4:0]  nv_ff, nv_in;
   logic        done_ff, done_in;
   logic [63:0] h_ff [8];
   logic [63:0] h_in [8];
   logic [63:0] v_ff [16];
   logic [63:0] v_in [16];
   logic [63:0] tmp  [16];

   logic [63:0] mem [BLOCK_WORDS];
   logic [63:0] md_ff;
   logic        mz_ff;
   logic        rd_en;
   logic [3:0]  rd_addr;
   logic [3:0]  rn;
   logic [2:0]  gn;

   logic [63:0] mx, add_x, add_y, add_z, sum, xr, rot;
   logic [3:0][1:0] amt;

   // Row rotation after each G: also (un)diagonalizes at the phase boundaries
   function automatic logic [3:0][1:0] row_amt(input logic [2:0] g);
      logic [3:0][1:0] a;
      case (g)
         3'd3:    a = {2'd0, 2'd3, 2'd2, 2'd1};
         3'd7:    a = {2'd2, 2'd3, 2'd0, 2'd1};
         default: a = {2'd1, 2'd1, 2'd1, 2'd1};
      endcase
      return a;
   endfunction

   // Shared quarter-G unit: one 3-input add, xor, fixed rotate
   always_comb begin
      mx = mz_ff ? 64'd0 : md_ff;
      case (q_ff)
         2'd0, 2'd2: begin
            add_x = v_ff[0];
            add_y = v_ff[4];
            add_z = mx;
         end
         default: begin
            add_x = v_ff[8];
            add_y = v_ff[12];
            add_z = 64'd0;
         end
      endcase
      sum = add_x + add_y + add_z;
      xr  = q_ff[0] ? (v_ff[4] ^ sum) : (v_ff[12] ^ sum);
      case (q_ff)
         2'd0:    rot = {xr[31:0], xr[63:32]};
         2'd1:    rot = {xr[23:0], xr[63:24]};
         2'd2:    rot = {xr[15:0], xr[63:16]};
         default: rot = {xr[62:0], xr[63]};
      endcase
      amt = row_amt(g_ff);
   end

   // Next schedule position, for the message read in the cycle before its use
   always_comb begin
      gn = g_ff + 3'd1;
      if (g_ff == 3'd7) begin
         rn = (r_ff == LastRound) ? 4'd0 : r_ff + 4'd1;
      end else begin
         rn = r_ff;
      end
      rd_en   = 1'b0;
      rd_addr = PERM[0][0];
      if (state_ff == C_LOAD) begin
         rd_en = 1'b1;
      end else if (state_ff == C_RUN && q_ff == 2'd1) begin
         rd_en   = 1'b1;
         rd_addr = PERM[r_ff][{g_ff, 1'b1}];
      end else if (state_ff == C_RUN && q_ff == 2'd3) begin
         rd_en   = 1'b1;
         rd_addr = PERM[rn][{gn, 1'b0}];
      end
   end

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      g_in     = g_ff;
      q_in     = q_ff;
      final_in = final_ff;
      nv_in    = nv_ff;
      done_in  = 1'b0;
      h_in     = h_ff;
      v_in     = v_ff;
      tmp      = v_ff;

      case (state_ff)
         C_IDLE: begin
            if (ctrl.start) begin
               final_in = ctrl.final_blk;
               nv_in    = ctrl.nv;
               state_in = C_LOAD;
            end
         end
         C_LOAD: begin
            for (int i = 0; i < 8; i++) begin
               v_in[i] = h_ff[i];
            end
            for (int i = 0; i < 4; i++) begin
               v_in[8 + i] = IV[i];
            end
            v_in[12] = IV[4] ^ ctrl.cnt_lo;
            v_in[13] = IV[5] ^ ctrl.cnt_hi;
            v_in[14] = final_ff ? ~IV[6] : IV[6];
            v_in[15] = IV[7];
            r_in     = 4'd0;
            g_in     = 3'd0;
            q_in     = 2'd0;
            state_in = C_RUN;
         end
         C_RUN: begin
            if (!q_ff[0]) begin
               tmp[0]  = sum;
               tmp[12] = rot;
            end else begin
               tmp[8] = sum;
               tmp[4] = rot;
            end
            v_in = tmp;
            q_in = q_ff + 2'd1;
            if (q_ff == 2'd3) begin
               for (int rw = 0; rw < 4; rw++) begin
                  for (int cl = 0; cl < 4; cl++) begin
                     v_in[{2'(rw), 2'(cl)}] = tmp[{2'(rw), 2'(cl) + amt[rw]}];
                  end
               end
               g_in = gn;
               if (g_ff == 3'd7) begin
                  r_in = r_ff + 4'd1;
                  if (r_ff == LastRound) begin
                     state_in = C_FOLD;
                  end
               end
            end
         end
         C_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] ^ v_ff[i] ^ v_ff[i + 8];
            end
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase

      if (ctrl.shift) begin
         for (int i = 0; i < 7; i++) begin
            h_in[i] = h_ff[i + 1];
         end
      end
      if (ctrl.reinit) begin
         h_in = HInit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         r_ff     <= 4'd0;
         g_ff     <= 3'd0;
         q_ff     <= 2'd0;
         final_ff <= 1'b0;
         nv_ff    <= 5'd0;
         done_ff  <= 1'b0;
         h_ff     <= HInit;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         g_ff     <= g_in;
         q_ff     <= q_in;
         final_ff <= final_in;
         nv_ff    <= nv_in;
         done_ff  <= done_in;
         h_ff     <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   // Block buffer: one write port, one registered read port.
   // Words at or past the fill count read as zero, so no clearing is needed.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (rd_en) begin
         md_ff <= mem[rd_addr];
         mz_ff <= ({1'b0, rd_addr} >= nv_ff);
      end
   end

   assign stat.done = done_ff;
   assign stat.h0   = h_ff[0];

endmodule

@@ hw/rtl/blake2b_384_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLAKE2b-384 hash
// Unkeyed BLAKE2b with a DIGEST_WORDS x 64-bit digest over a word stream.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one message word per transfer, little-endian, with its count of
//    valid bytes (values above 8 count as 8) and a flag on the final word.
//    An empty message is a single final word with zero valid bytes.
//  - rsp_*: after the final word, DIGEST_WORDS digest words in order;
//    rsp_digest_last marks the last one.
//  - Flow: a word that only fills the buffer is written with no compression. A
//    word that follows a full block first waits for that block's compression.
//    rsp_valid rises once the final block is compressed, after the held
//    full block when that is compressed first; digest words then go out
//    one per cycle while rsp_stall is low.
//  - The compression time comes from the single shared quarter-G adder,
//    stepped a quarter G at a time: 8 G steps per round, 12 rounds.
//  - req_stall is high from the cycle after a transfer until the word is
//    absorbed or its digest fully delivered: one word is in flight at a time.
//  - When rsp_stall is high the current digest word holds; nothing advances.
//  - Reset (synchronous) restores the initial chain value, a zero byte
//    count and an empty buffer; the same happens after the last digest word.
// ----------------------------------------------------------------------------
`include "blake2b_384_hash_macros.svh"

module blake2b_384_hash #(
   parameter int DIGEST_WORDS = b2b_pkg::DIGEST_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_msg_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic        rsp_digest_last
);
   import b2b_pkg::*;

   localparam int         IdxW      = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(DIGEST_WORDS - 1);
   localparam logic [4:0] FullBlock = 5'(BLOCK_WORDS);

   typedef enum logic [2:0] {
      T_IDLE, T_CHECK, T_HI_NF, T_WAIT_NF, T_PLACE, T_HI_F, T_WAIT_F, T_OUT
   } tst_type;

   tst_type          state_ff, state_in;
   logic [63:0]      word_ff, word_in;
   logic [3:0]       nb_ff, nb_in;
   logic             last_ff, last_in;
   logic [4:0]       wb_ff, wb_in;
   logic [63:0]      cnt_lo_ff, cnt_lo_in;
   logic [63:0]      cnt_hi_ff, cnt_hi_in;
   logic             carry_ff, carry_in;
   logic [IdxW-1:0]  idx_ff, idx_in;

   logic [3:0]       nb_sat;
   logic [63:0]      word_mask;
   logic [7:0]       used;

   core_ctrl_type    core_ctrl;
   core_stat_type    core_stat;

   b2b_core #(
      .DIGEST_WORDS (DIGEST_WORDS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (core_ctrl),
      .stat  (core_stat)
   );

   // Saturate the byte count and zero the bytes past it
   always_comb begin
      nb_sat = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
      for (int b = 0; b < 8; b++) begin
         word_mask[8*b +: 8] = (4'(b) < nb_sat) ? 8'hFF : 8'h00;
      end
   end

   // Bytes counted with the final word; a held full block counts 128
   assign used = wb_ff[4] ? 8'd128 : {wb_ff, 3'b000} + {4'd0, nb_ff};

   assign req_stall       = (state_ff != T_IDLE);
   assign rsp_valid       = (state_ff == T_OUT);
   assign rsp_digest_word = core_stat.h0;
   assign rsp_digest_last = (idx_ff == LastIdx);

   always_comb begin
      state_in  = state_ff;
      word_in   = word_ff;
      nb_in     = nb_ff;
      last_in   = last_ff;
      wb_in     = wb_ff;
      cnt_lo_in = cnt_lo_ff;
      cnt_hi_in = cnt_hi_ff;
      carry_in  = carry_ff;
      idx_in    = idx_ff;

      core_ctrl           = '0;
      core_ctrl.cnt_lo    = cnt_lo_ff;
      core_ctrl.cnt_hi    = cnt_hi_ff;
      core_ctrl.wr_addr   = wb_ff[3:0];
      core_ctrl.wr_data   = word_ff;
      core_ctrl.nv        = wb_ff[4] ? FullBlock : wb_ff + 5'd1;

      case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               word_in  = req_msg_word & word_mask;
               nb_in    = nb_sat;
               last_in  = req_last_word;
               state_in = T_CHECK;
            end
         end
         T_CHECK: begin
            // A held full block is compressed non-final unless the message
            // ends here with an empty word, which makes it the final block.
            if (wb_ff[4] && !(last_ff && nb_ff == 4'd0)) begin
               {carry_in, cnt_lo_in} = {1'b0, cnt_lo_ff} + 65'd128;
               state_in = T_HI_NF;
            end else begin
               state_in = T_PLACE;
            end
         end
         T_HI_NF: begin
            cnt_hi_in           = cnt_hi_ff + 64'(carry_ff);
            core_ctrl.start     = 1'b1;
            core_ctrl.final_blk = 1'b0;
            core_ctrl.nv        = FullBlock;
            state_in            = T_WAIT_NF;
         end
         T_WAIT_NF: begin
            if (core_stat.done) begin
               wb_in    = 5'd0;
               state_in = T_PLACE;
            end
         end
         T_PLACE: begin
            core_ctrl.wr_en = !wb_ff[4];
            if (!last_ff) begin
               wb_in    = wb_ff + 5'd1;
               state_in = T_IDLE;
            end else begin
               {carry_in, cnt_lo_in} = {1'b0, cnt_lo_ff} + {57'd0, used};
               state_in = T_HI_F;
            end
         end
         T_HI_F: begin
            cnt_hi_in           = cnt_hi_ff + 64'(carry_ff);
            core_ctrl.start     = 1'b1;
            core_ctrl.final_blk = 1'b1;
            state_in            = T_WAIT_F;
         end
         T_WAIT_F: begin
            if (core_stat.done) begin
               idx_in   = '0;
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (!rsp_stall) begin
               core_ctrl.shift = 1'b1;
               if (idx_ff == LastIdx) begin
                  // back to the reset state for the next message
                  core_ctrl.reinit = 1'b1;
                  wb_in     = 5'd0;
                  cnt_lo_in = 64'd0;
                  cnt_hi_in = 64'd0;
                  state_in  = T_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= T_IDLE;
         wb_ff     <= 5'd0;
         cnt_lo_ff <= 64'd0;
         cnt_hi_ff <= 64'd0;
         carry_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         wb_ff     <= wb_in;
         cnt_lo_ff <= cnt_lo_in;
         cnt_hi_ff <= cnt_hi_in;
         carry_ff  <= carry_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      nb_ff   <= nb_in;
      last_ff <= last_in;
   end

   `B2B_ASSERT_IMPL(a_wb_range, 1'b1, wb_ff <= FullBlock, "buffer count past a full block")
   `B2B_ASSERT_IMPL(a_out_holds_in, rsp_valid, req_stall, "input open during digest output")
   `B2B_ASSERT_NEXT(a_one_word, req_valid && !req_stall, state_ff == T_CHECK,
                    "accepted word not taken up")
   `B2B_ASSERT_IMPL(a_done_waited, core_stat.done,
                    state_ff == T_WAIT_NF || state_ff == T_WAIT_F,
                    "compression finished with no one waiting")

endmodule
